// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- src/swd_pkg.sv -----
`default_nettype none
package swd_pkg;
  // Largest number of candidate nodes the stake memory holds.
  localparam int MAX_NODES = 256;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DRAW    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_BAD     = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_SHARD_COUNT = 2'd1;
  localparam int         CFG_IDX_W       = 2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  node_index;
    logic [31:0] stake_value;
    logic [30:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] winner_index;
    logic [7:0] shard_number;
    logic       status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SUM,
    ST_SUM_LAST,
    ST_MOD,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_FIRST,
    ST_FIRST_LAST,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_idx;
    logic clr_acc;
    logic adv_idx;
    logic add_sum;
    logic mod_init;
    logic mod_step;
    logic scan_step;
    logic first_step;
    logic clear_step;
    logic commit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic mod_done;
    logic found;
    logic clear_last;
  } sts_t;
endpackage
`default_nettype wire

// ----- src/swd_ctrl.sv -----
`default_nettype none
module swd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go_draw,
  input  wire logic            go_restart,
  input  wire swd_pkg::sts_t   sts,
  output swd_pkg::state_t      state,
  output swd_pkg::ctl_t        ctl
);
  swd_pkg::state_t state_r, state_nxt;

  assign state = state_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swd_pkg::ST_IDLE: begin
        if (go_draw) state_nxt = swd_pkg::ST_SUM;
        else if (go_restart) state_nxt = swd_pkg::ST_CLEAR;
      end
      swd_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = swd_pkg::ST_IDLE;
      end
      swd_pkg::ST_SUM: begin
        if (sts.idx_last) state_nxt = swd_pkg::ST_SUM_LAST;
      end
      swd_pkg::ST_SUM_LAST: state_nxt = swd_pkg::ST_MOD;
      swd_pkg::ST_MOD: begin
        if (sts.mod_done) state_nxt = swd_pkg::ST_SCAN;
      end
      swd_pkg::ST_SCAN: begin
        if (sts.found) state_nxt = swd_pkg::ST_DONE;
        else if (sts.idx_last) state_nxt = swd_pkg::ST_SCAN_LAST;
      end
      swd_pkg::ST_SCAN_LAST: state_nxt = sts.found ? swd_pkg::ST_DONE : swd_pkg::ST_FIRST;
      swd_pkg::ST_FIRST: begin
        if (sts.found) state_nxt = swd_pkg::ST_DONE;
        else if (sts.idx_last) state_nxt = swd_pkg::ST_FIRST_LAST;
      end
      swd_pkg::ST_FIRST_LAST: state_nxt = swd_pkg::ST_DONE;
      swd_pkg::ST_DONE: state_nxt = swd_pkg::ST_IDLE;
      default: state_nxt = swd_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      swd_pkg::ST_IDLE: begin
        ctl.clr_idx = 1'b1;
        ctl.clr_acc = 1'b1;
      end
      swd_pkg::ST_CLEAR: ctl.clear_step = 1'b1;
      swd_pkg::ST_SUM: begin
        ctl.adv_idx = 1'b1;
        ctl.add_sum = 1'b1;
      end
      swd_pkg::ST_SUM_LAST: ctl.add_sum = 1'b1;
      swd_pkg::ST_MOD: begin
        ctl.mod_step = 1'b1;
        ctl.clr_idx  = 1'b1;
      end
      swd_pkg::ST_SCAN: begin
        ctl.adv_idx   = 1'b1;
        ctl.scan_step = 1'b1;
      end
      swd_pkg::ST_SCAN_LAST: begin
        ctl.scan_step = 1'b1;
        ctl.clr_idx   = 1'b1;
      end
      swd_pkg::ST_FIRST: begin
        ctl.adv_idx    = 1'b1;
        ctl.first_step = 1'b1;
      end
      swd_pkg::ST_FIRST_LAST: ctl.first_step = 1'b1;
      swd_pkg::ST_DONE: ctl.commit = 1'b1;
      default: ctl = '0;
    endcase
    if (state_r == swd_pkg::ST_SUM_LAST) ctl.mod_init = 1'b1;
  end
endmodule
`default_nettype wire

// ----- src/swd_data.sv -----
`default_nettype none
module swd_data (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire swd_pkg::ctl_t           ctl,
  input  wire logic [8:0]              n_live,
  input  wire logic [30:0]             rnd,
  input  wire logic                    ld_we,
  input  wire logic [7:0]              ld_idx,
  input  wire logic [31:0]             ld_stake,
  input  wire logic                    restart_now,
  output swd_pkg::sts_t                sts,
  output logic                         any_found,
  output logic [7:0]                   win_idx
);
  localparam int IW = $clog2(swd_pkg::MAX_NODES);

  logic [31:0]   stake_mem [swd_pkg::MAX_NODES];
  logic [31:0]   rd_stake;
  logic [swd_pkg::MAX_NODES-1:0] used_r;
  logic [IW-1:0] idx_r, rd_idx_r, clr_r;
  logic          rd_used_r;
  logic [39:0]   acc_r;
  logic [39:0]   rem_r;
  logic [39:0]   den_r;
  logic [5:0]    mcnt_r;
  logic [39:0]   pick_r;
  logic          found_r;
  logic [IW-1:0] win_r;
  logic [IW:0]   last_idx;
  logic [39:0]   run_sum;
  logic          rd_ok;

  // Stake memory: one write port for loads, registered read for the sum and scan walks.
  always_ff @(posedge clk) begin
    if (ld_we) stake_mem[ld_idx[IW-1:0]] <= ld_stake;
    rd_stake <= stake_mem[idx_r];
  end

  assign last_idx = {1'b0, idx_r} + (IW+1)'(1);
  assign sts.idx_last = ((IW+1)'(n_live) <= last_idx) || (&idx_r);
  assign sts.clear_last = &clr_r;
  assign sts.found = found_r;
  assign any_found = found_r;
  assign win_idx = 8'(win_r);

  assign run_sum = acc_r + 40'(rd_stake);

  // The first cycle of a walk still shows the word read before the walk began,
  // so it is skipped; the closing cycle of a walk always holds valid data.
  assign rd_ok = (idx_r != '0) || !ctl.adv_idx;

  // Index walk, clear sweep, and read pipeline tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      clr_r <= '0;
    end else begin
      if (ctl.clr_idx) idx_r <= '0;
      else if (ctl.adv_idx && !(&idx_r)) idx_r <= idx_r + IW'(1);
      if (ctl.clear_step) clr_r <= clr_r + IW'(1);
    end
    rd_idx_r  <= idx_r;
    rd_used_r <= used_r[idx_r];
  end

  // Sum, modulo by restoring shift-subtract, both scans, and the used marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      found_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      if (ctl.clr_acc) begin
        acc_r   <= '0;
        found_r <= 1'b0;
      end
      if (ctl.add_sum && !rd_used_r && (ctl.mod_init || (idx_r != '0)))
        acc_r <= run_sum;
      if (ctl.mod_init) begin
        den_r  <= (!rd_used_r) ? run_sum : acc_r;
        rem_r  <= '0;
        pick_r <= 40'(rnd);
        mcnt_r <= 6'd31;
      end
      if (ctl.mod_step) begin
        acc_r <= '0;
        if (den_r == '0) begin
          rem_r  <= '0;
          mcnt_r <= '0;
        end else if (mcnt_r != '0) begin
          if (({rem_r[38:0], pick_r[30]}) >= den_r)
            rem_r <= {rem_r[38:0], pick_r[30]} - den_r;
          else rem_r <= {rem_r[38:0], pick_r[30]};
          pick_r <= {pick_r[38:0], 1'b0};
          mcnt_r <= mcnt_r - 6'd1;
        end
      end
      if (ctl.scan_step && !found_r && !rd_used_r && rd_ok) begin
        acc_r <= run_sum;
        if (run_sum > rem_r) begin
          found_r <= 1'b1;
          win_r   <= rd_idx_r;
        end
      end
      if (ctl.first_step && !found_r && !rd_used_r && rd_ok) begin
        found_r <= 1'b1;
        win_r   <= rd_idx_r;
      end
      if (ctl.commit && found_r) used_r[win_r] <= 1'b1;
      if (ctl.clear_step || restart_now) used_r <= '0;
    end
  end

  assign sts.mod_done = (mcnt_r == '0) || (den_r == '0);
endmodule
`default_nettype wire

// ----- src/stake_weighted_draw_without_replacement.sv -----
`default_nettype none
// Channel | Ports                               | Transfer
// input   | start, busy, in_item                | start high while busy low
// result  | out_valid, out_item                 | one cycle strobe, no stall
// config  | cfg_valid, cfg_ready, cfg_idx/data  | valid and ready high
// Load, restart and bad items finish without entering the draw states. A draw
// keeps busy high for a sum walk and a scan walk over the stake memory's read
// port plus a shift-subtract modulo. When all remaining stakes are zero the
// modulo does no steps and a third walk finds the lowest unused node.
// Reset clears used marks at once.
// The result strobe cannot be stalled; busy stays high until it is shown.
module stake_weighted_draw_without_replacement (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire swd_pkg::in_item_t          in_item,
  output logic                            out_valid,
  output swd_pkg::out_item_t              out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [swd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [8:0]                 cfg_data
);
`include "assert_macros.svh"
  logic [8:0] node_count_r, shard_count_r, shards_r, n_live;
  logic       pend_r;
  logic [30:0] rnd_r;
  swd_pkg::out_item_t res_r;
  logic       accept, go_draw, draw_ok;
  swd_pkg::state_t state;
  swd_pkg::ctl_t   ctl;
  swd_pkg::sts_t   sts;
  logic       any_found;
  logic [7:0] win_idx;
  logic       ld_we, restart_now;
  logic [1:0] cmd;

  assign cfg_ready = 1'b1;
  assign n_live = (node_count_r > 9'(swd_pkg::MAX_NODES)) ? 9'(swd_pkg::MAX_NODES)
                                                          : node_count_r;
  assign accept = start && !busy;
  assign cmd = in_item.command;
  assign busy = pend_r || (state != swd_pkg::ST_IDLE) || out_valid;
  assign draw_ok = (n_live != '0) && (shard_count_r != '0) &&
                   (shard_count_r <= n_live) && (shards_r < shard_count_r);
  assign go_draw = accept && (cmd == swd_pkg::CMD_DRAW) && draw_ok;
  assign ld_we = accept && (cmd == swd_pkg::CMD_LOAD) && (9'(in_item.node_index) < n_live);
  assign restart_now = accept && (cmd == swd_pkg::CMD_RESTART);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= 9'd1;
      shard_count_r <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx)
        swd_pkg::CFG_NODE_COUNT:  node_count_r  <= cfg_data;
        swd_pkg::CFG_SHARD_COUNT: shard_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result and shard bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
      shards_r  <= '0;
    end else begin
      out_valid <= 1'b0;
      if (accept) rnd_r <= in_item.random_value;
      if (accept && !go_draw) begin
        out_valid <= 1'b1;
        res_r <= '{winner_index: 8'd0, shard_number: 8'd0,
                   status: !(ld_we || restart_now)};
        if (restart_now) shards_r <= '0;
      end
      if (state == swd_pkg::ST_DONE) begin
        out_valid <= 1'b1;
        if (any_found) begin
          res_r <= '{winner_index: win_idx, shard_number: shards_r[7:0], status: 1'b0};
          shards_r <= shards_r + 9'd1;
        end else begin
          res_r <= '{winner_index: 8'd0, shard_number: 8'd0, status: 1'b1};
        end
      end
      pend_r <= 1'b0;
    end
  end
  assign out_item = res_r;

  swd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go_draw(go_draw), .go_restart(1'b0),
    .sts(sts), .state(state), .ctl(ctl)
  );

  swd_data u_data (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .n_live(n_live), .rnd(rnd_r),
    .ld_we(ld_we), .ld_idx(in_item.node_index), .ld_stake(in_item.stake_value),
    .restart_now(restart_now), .sts(sts), .any_found(any_found), .win_idx(win_idx)
  );

  `ASSERT_IMPLIES(a_busy_draw, clk, rst_n, state != swd_pkg::ST_IDLE, busy)
  `ASSERT_NEXT(a_draw_starts, clk, rst_n, go_draw, state == swd_pkg::ST_SUM)
  `ASSERT_NEXT(a_done_strobe, clk, rst_n, state == swd_pkg::ST_DONE, out_valid)
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int NODE_LIMIT  = 256;
  localparam int CYCLE_LIMIT = 3000000;

  typedef enum logic [1:0] {ROW_ITEM, ROW_NODES, ROW_SHARDS} row_kind_t;

  // One directed row: an item or a register write, with an optional typed answer.
  typedef struct {
    row_kind_t kind;
    swd_pkg::in_item_t  item;
    logic [8:0] value;
    bit        typed;
    swd_pkg::out_item_t answer;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  swd_pkg::in_item_t in_item = '0;
  logic out_valid;
  swd_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [swd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [8:0] cfg_data = '0;

  // Predictor state.
  logic [31:0] stake_mem [NODE_LIMIT];
  bit          stake_known [NODE_LIMIT];
  bit          node_used [NODE_LIMIT];
  logic [8:0]  shards_taken;
  logic [8:0]  nodes_cfg;
  logic [8:0]  shards_cfg;

  swd_pkg::out_item_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int winners_seen = 0;
  int rejects_seen = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  stake_weighted_draw_without_replacement i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned live_nodes();
    return (nodes_cfg > NODE_LIMIT) ? NODE_LIMIT : nodes_cfg;
  endfunction

  function automatic bit draw_rejected_early();
    int unsigned n;
    n = live_nodes();
    return (n == 0) || (shards_cfg == 0) || (shards_cfg > n) || (shards_taken >= shards_cfg);
  endfunction

  // A draw reads every stake below the node count, so all must be known.
  function automatic bit draw_is_safe();
    int unsigned n;
    n = live_nodes();
    if (draw_rejected_early()) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!stake_known[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Roulette-wheel election: computes the result and advances the state.
  function automatic swd_pkg::out_item_t elect(swd_pkg::in_item_t it);
    swd_pkg::out_item_t r;
    int unsigned n;
    logic [63:0] total, pick, run;
    int win;
    bit found;
    r = '0;
    n = live_nodes();
    total = 0;
    run = 0;
    win = 0;
    found = 1'b0;
    case (swd_pkg::cmd_t'(it.command))
      swd_pkg::CMD_LOAD: begin
        if (it.node_index >= n) begin
          r.status = 1'b1;
        end else begin
          stake_mem[it.node_index] = it.stake_value;
          stake_known[it.node_index] = 1'b1;
        end
      end
      swd_pkg::CMD_RESTART: begin
        for (int i = 0; i < NODE_LIMIT; i++) node_used[i] = 1'b0;
        shards_taken = '0;
      end
      swd_pkg::CMD_DRAW: begin
        if (draw_rejected_early()) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!node_used[i]) total += stake_mem[i];
          end
          pick = (total > 0) ? ({33'd0, it.random_value} % total) : 64'd0;
          for (int i = 0; i < n && !found; i++) begin
            if (!node_used[i]) begin
              run += stake_mem[i];
              if (run > pick) begin
                win = i;
                found = 1'b1;
              end
            end
          end
          // All remaining stakes zero: the lowest unused node wins.
          for (int i = 0; i < n && !found; i++) begin
            if (!node_used[i]) begin
              win = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = 1'b1;
          end else begin
            node_used[win] = 1'b1;
            r.winner_index = win[7:0];
            r.shard_number = shards_taken[7:0];
            shards_taken = shards_taken + 9'd1;
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // Result checker: the receiver takes every strobe.
  always @(posedge clk) begin
    swd_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: winner %0d shard %0d status %0d", $time,
                 out_item.winner_index, out_item.shard_number, out_item.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.winner_index !== want.winner_index) begin
          $display("%0t winner_index mismatch: expected %0d actual %0d", $time,
                   want.winner_index, out_item.winner_index);
          errors++;
        end
        if (out_item.shard_number !== want.shard_number) begin
          $display("%0t shard_number mismatch: expected %0d actual %0d", $time,
                   want.shard_number, out_item.shard_number);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   want.status, out_item.status);
          errors++;
        end
        if (out_item.status === 1'b0 && want.status == 1'b0 &&
            out_item.winner_index != 0) winners_seen++;
        if (out_item.status === 1'b1) rejects_seen++;
      end
    end
  end

  // Presents one item after a random gap, or none when gaps are off, and waits for its transfer.
  task automatic send_item(swd_pkg::in_item_t it, bit typed, swd_pkg::out_item_t answer);
    int gap;
    swd_pkg::out_item_t got;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    got = elect(it);
    pending_results.push_back(typed ? answer : got);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_reg(logic [swd_pkg::CFG_IDX_W-1:0] idx, logic [8:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == swd_pkg::CFG_NODE_COUNT) nodes_cfg = value;
    else if (idx == swd_pkg::CFG_SHARD_COUNT) shards_cfg = value;
  endtask

  function automatic swd_pkg::in_item_t make_item(swd_pkg::cmd_t c, logic [7:0] idx,
                                                  logic [31:0] stake, logic [30:0] rnd);
    swd_pkg::in_item_t it;
    it.command = c;
    it.node_index = idx;
    it.stake_value = stake;
    it.random_value = rnd;
    return it;
  endfunction

  function automatic logic [31:0] random_stake();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom_range(0, 100);
      2: return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // One setting of the registers, a restart, the missing stakes and some others loaded, then random traffic.
  task automatic run_phase(logic [8:0] nodes, logic [8:0] shards, int count);
    swd_pkg::in_item_t it;
    int unsigned n;
    int roll;
    write_reg(swd_pkg::CFG_NODE_COUNT, nodes);
    write_reg(swd_pkg::CFG_SHARD_COUNT, shards);
    send_item(make_item(swd_pkg::CMD_RESTART, 8'($urandom), $urandom, 31'($urandom)),
              1'b0, '0);
    n = live_nodes();
    for (int i = 0; i < n; i++) begin
      if (!stake_known[i] || $urandom_range(0, 3) == 0)
        send_item(make_item(swd_pkg::CMD_LOAD, i[7:0], random_stake(), 31'($urandom)),
                  1'b0, '0);
    end
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 49) begin
        no_gaps = !no_gaps;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (shards_taken >= shards_cfg && shards_cfg != 0 && roll < 70) roll = 95;
      if (roll < 72) begin
        it = make_item(swd_pkg::CMD_DRAW, 8'($urandom), $urandom, 31'($urandom));
      end else if (roll < 85) begin
        it = make_item(swd_pkg::CMD_LOAD,
                       (roll < 82 && n > 0) ? 8'($urandom_range(0, n - 1))
                                            : 8'($urandom_range(0, 255)),
                       random_stake(), 31'($urandom));
      end else if (roll < 90) begin
        it = make_item(swd_pkg::CMD_BAD, 8'($urandom), $urandom, 31'($urandom));
      end else begin
        it = make_item(swd_pkg::CMD_RESTART, 8'($urandom), $urandom, 31'($urandom));
      end
      if (swd_pkg::cmd_t'(it.command) == swd_pkg::CMD_DRAW && !draw_is_safe())
        it = make_item(swd_pkg::CMD_RESTART, 8'($urandom), $urandom, 31'($urandom));
      send_item(it, 1'b0, '0);
    end
  endtask

  dir_row_t rows [$];

  function automatic void add_row(row_kind_t kind, swd_pkg::in_item_t it, logic [8:0] value,
                                  bit typed, swd_pkg::out_item_t answer);
    dir_row_t r;
    r.kind = kind;
    r.item = it;
    r.value = value;
    r.typed = typed;
    r.answer = answer;
    rows.push_back(r);
  endfunction

  initial begin
    swd_pkg::out_item_t ok, rejected;
    ok = '0;
    rejected = '0;
    rejected.status = 1'b1;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      stake_mem[i] = '0;
      stake_known[i] = 1'b0;
      node_used[i] = 1'b0;
    end
    shards_taken = '0;
    nodes_cfg = 9'd1;
    shards_cfg = 9'd1;

    // Directed rows: reset counts first, then a four-node election and bad counts.
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd1, 32'd5, '0), '0, 1'b1, rejected);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, '0), '0, 1'b1,
            rejected);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_BAD, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF), '0,
            1'b1, rejected);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd0, 32'hFFFF_FFFF, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'h7FFF_FFFF), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd3), '0, 1'b1, rejected);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_RESTART, 8'd0, '0, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd0, 32'd0, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_RESTART, 8'd0, '0, '0), '0, 1'b1, ok);
    add_row(ROW_NODES, '0, 9'd4, 1'b0, ok);
    add_row(ROW_SHARDS, '0, 9'd4, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd1, 32'd10, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd2, 32'd0, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd3, 32'h8000_0000, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'h7FFF_FFFF), '0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd0), '0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd9), '0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd1), '0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd1), '0, 1'b1, rejected);
    add_row(ROW_SHARDS, '0, 9'd5, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_RESTART, 8'd0, '0, '0), '0, 1'b1, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd1), '0, 1'b1, rejected);
    add_row(ROW_SHARDS, '0, 9'd0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_DRAW, 8'd0, '0, 31'd1), '0, 1'b1, rejected);
    add_row(ROW_NODES, '0, 9'd0, 1'b0, ok);
    add_row(ROW_ITEM, make_item(swd_pkg::CMD_LOAD, 8'd0, 32'd1, '0), '0, 1'b1, rejected);

    // Hold reset, then release it.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_NODES: write_reg(swd_pkg::CFG_NODE_COUNT, rows[i].value);
        ROW_SHARDS: write_reg(swd_pkg::CFG_SHARD_COUNT, rows[i].value);
        default: send_item(rows[i].item, rows[i].typed, rows[i].answer);
      endcase
    end

    // Random part: fixed settings, the extremes among them, then random small elections.
    run_phase(9'd256, 9'd256, 150);
    run_phase(9'd3, 9'd3, 60);
    run_phase(9'd511, 9'd200, 40);
    run_phase(9'd16, 9'd5, 80);
    run_phase(9'd2, 9'd1, 50);
    run_phase(9'd8, 9'd0, 20);
    run_phase(9'd6, 9'd7, 20);
    run_phase(9'd1, 9'd1, 30);
    while (items_sent < 900) begin
      int unsigned n;
      n = $urandom_range(1, 20);
      run_phase(n[8:0], 9'($urandom_range(1, n)), 40);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d items over settings from zero to 511 nodes; %0d draws won by a",
             items_sent, winners_seen);
    $display("nonzero node, %0d rejections checked.", rejects_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
